### rtl/swmm_pkg.sv
// shared constants and types for the sliding window min/max block
package swmm_pkg;

    localparam int WINDOW_MAX_DEF   = 64;
    localparam int SAMPLE_WIDTH_DEF = 32;
    localparam int CFG_WIDTH        = 7;

    localparam logic [CFG_WIDTH-1:0] WINDOW_RESET = 7'd1;

    // per-cycle command broadcast to every cell of one deque
    typedef struct packed {
        logic accept;   // a sample beat is taken this cycle
        logic shift;    // cells take their contents from the next cell
        logic drop;     // drain one stale front entry, no sample
    } cell_ctrl_t;

endpackage

### rtl/swmm_sample_if.sv
// sample channel: valid, ready and one signed sample
interface swmm_sample_if #(
    parameter int SAMPLE_WIDTH = swmm_pkg::SAMPLE_WIDTH_DEF
) ();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

### rtl/swmm_result_if.sv
// result channel: valid, ready and the window minimum and maximum
interface swmm_result_if #(
    parameter int SAMPLE_WIDTH = swmm_pkg::SAMPLE_WIDTH_DEF
) ();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] window_min;
    logic signed [SAMPLE_WIDTH-1:0] window_max;

    modport source (output valid, output window_min, output window_max, input ready);
    modport sink (input valid, input window_min, input window_max, output ready);
endinterface

### rtl/swmm_cfg_if.sv
// configuration write channel carrying the window size
interface swmm_cfg_if ();
    logic                           valid;
    logic                           ready;
    logic [swmm_pkg::CFG_WIDTH-1:0] window_size;

    modport source (output valid, output window_size, input ready);
    modport sink (input valid, input window_size, output ready);
endinterface

### rtl/swmm_cell.sv
// one deque slot: value, position and valid, fed by itself, its right neighbor or the new sample
module swmm_cell #(
    parameter bit IS_MIN       = 1'b1,
    parameter bit IS_HEAD      = 1'b0,
    parameter int SAMPLE_WIDTH = swmm_pkg::SAMPLE_WIDTH_DEF,
    parameter int POS_W        = 7,
    parameter int POS_MOD      = 128,
    parameter int WIN_W        = 7
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  swmm_pkg::cell_ctrl_t           ctrl,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    input  logic        [POS_W-1:0]        pos_now,
    input  logic        [WIN_W-1:0]        win_eff,
    input  logic signed [SAMPLE_WIDTH-1:0] nb_value,
    input  logic        [POS_W-1:0]        nb_pos,
    input  logic                           nb_valid,
    input  logic                           nb_kept,
    input  logic                           prev_kept,
    output logic signed [SAMPLE_WIDTH-1:0] value,
    output logic        [POS_W-1:0]        pos,
    output logic                           valid,
    output logic                           kept,
    output logic                           stale,
    output logic signed [SAMPLE_WIDTH-1:0] value_next_out
);
    import swmm_pkg::*;

    logic signed [SAMPLE_WIDTH-1:0] value_reg, value_next;
    logic        [POS_W-1:0]        pos_reg, pos_next;
    logic                           valid_reg, valid_next;

    logic        [POS_W:0]          age;
    logic                           dominated;
    logic signed [SAMPLE_WIDTH-1:0] src_value;
    logic        [POS_W-1:0]        src_pos;
    logic                           src_valid;
    logic                           src_kept;
    logic                           prev_ok;

    // age modulo the position range
    always_comb
    begin
        if (pos_now >= pos_reg)
        begin
            age = {1'b0, pos_now} - {1'b0, pos_reg};
        end
        else
        begin
            age = {1'b0, pos_now} + (POS_W+1)'(POS_MOD) - {1'b0, pos_reg};
        end
    end

    assign stale     = valid_reg && (32'(age) >= 32'(win_eff));
    assign dominated = IS_MIN ? (sample < value_reg) : (sample > value_reg);
    assign kept      = valid_reg && !stale && !dominated;

    always_comb
    begin
        src_value = ctrl.shift ? nb_value : value_reg;
        src_pos   = ctrl.shift ? nb_pos : pos_reg;
        src_valid = ctrl.shift ? nb_valid : valid_reg;
        src_kept  = ctrl.shift ? nb_kept : kept;
        // the push lands right after the last survivor, or at the head
        prev_ok   = IS_HEAD ? 1'b1 : (ctrl.shift ? kept : prev_kept);

        value_next = value_reg;
        pos_next   = pos_reg;
        valid_next = valid_reg;
        if (ctrl.accept)
        begin
            if (src_kept)
            begin
                value_next = src_value;
                pos_next   = src_pos;
                valid_next = 1'b1;
            end
            else if (prev_ok)
            begin
                value_next = sample;
                pos_next   = pos_now;
                valid_next = 1'b1;
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
        else if (ctrl.drop)
        begin
            value_next = src_value;
            pos_next   = src_pos;
            valid_next = src_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        pos_reg   <= pos_next;
    end

    assign value          = value_reg;
    assign pos            = pos_reg;
    assign valid          = valid_reg;
    assign value_next_out = value_next;
endmodule

### rtl/swmm_deque.sv
// monotonic deque built as a row of cells, front at cell zero
module swmm_deque #(
    parameter bit IS_MIN       = 1'b1,
    parameter int WINDOW_MAX   = swmm_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_WIDTH = swmm_pkg::SAMPLE_WIDTH_DEF,
    parameter int POS_W        = 7,
    parameter int POS_MOD      = 128,
    parameter int WIN_W        = 7
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           accept,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    input  logic        [POS_W-1:0]        pos_now,
    input  logic        [WIN_W-1:0]        win_eff,
    output logic                           multi_stale,
    output logic signed [SAMPLE_WIDTH-1:0] front_next
);
    import swmm_pkg::*;

    logic signed [SAMPLE_WIDTH-1:0] value [WINDOW_MAX+1];
    logic signed [SAMPLE_WIDTH-1:0] value_nx [WINDOW_MAX];
    logic        [POS_W-1:0]        pos [WINDOW_MAX+1];
    logic        [WINDOW_MAX:0]     valid;
    logic        [WINDOW_MAX:0]     kept;
    logic        [WINDOW_MAX-1:0]   stale;
    cell_ctrl_t                     ctrl;

    // past the last cell the row reads as empty
    assign value[WINDOW_MAX] = '0;
    assign pos[WINDOW_MAX]   = '0;
    assign valid[WINDOW_MAX] = 1'b0;
    assign kept[WINDOW_MAX]  = 1'b0;

    // more than one stale entry: drain them one per cycle first
    assign multi_stale = stale[1];

    always_comb
    begin
        ctrl.accept = accept;
        ctrl.drop   = !accept && stale[1];
        ctrl.shift  = accept ? stale[0] : stale[1];
    end

    for (genvar i = 0; i < WINDOW_MAX; i++)
    begin : g_cell
        swmm_cell #(
            .IS_MIN       (IS_MIN),
            .IS_HEAD      (i == 0),
            .SAMPLE_WIDTH (SAMPLE_WIDTH),
            .POS_W        (POS_W),
            .POS_MOD      (POS_MOD),
            .WIN_W        (WIN_W)
        ) u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .ctrl           (ctrl),
            .sample         (sample),
            .pos_now        (pos_now),
            .win_eff        (win_eff),
            .nb_value       (value[i+1]),
            .nb_pos         (pos[i+1]),
            .nb_valid       (valid[i+1]),
            .nb_kept        (kept[i+1]),
            .prev_kept      ((i == 0) ? 1'b1 : kept[(i == 0) ? 0 : i-1]),
            .value          (value[i]),
            .pos            (pos[i]),
            .valid          (valid[i]),
            .kept           (kept[i]),
            .stale          (stale[i]),
            .value_next_out (value_nx[i])
        );
    end

    assign front_next = value_nx[0];
endmodule

### rtl/sliding_window_min_max.sv
// sliding window minimum and maximum over a signed sample stream
// a result is registered and shows in the cycle after its sample beat
// throughput: one sample per cycle while the window size holds steady and results are taken
// after the window shrinks, stale front entries drain one at a time, the last one with the next sample
// reset: clears all deque valid bits, position, fill count and result valid; window size 1
module sliding_window_min_max #(
    parameter int WINDOW_MAX   = swmm_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_WIDTH = swmm_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    swmm_cfg_if.sink       cfg,
    swmm_sample_if.sink    samples,
    swmm_result_if.source  results
);
    import swmm_pkg::*;

    localparam int POS_MOD = 2 * WINDOW_MAX;
    localparam int POS_W   = $clog2(POS_MOD);
    localparam int WIN_W   = $clog2(WINDOW_MAX + 1);

    logic [CFG_WIDTH-1:0]           window_size_reg;
    logic [POS_W-1:0]               pos_reg, pos_next;
    logic [WIN_W-1:0]               fill_reg, fill_next;
    logic                           out_valid_reg, out_valid_next;
    logic signed [SAMPLE_WIDTH-1:0] window_min_reg, window_max_reg;

    logic [WIN_W-1:0]               win_eff;
    logic                           accept;
    logic                           min_multi, max_multi;
    logic signed [SAMPLE_WIDTH-1:0] min_front, max_front;

    // zero acts as one, oversize saturates
    always_comb
    begin
        if (window_size_reg == '0)
        begin
            win_eff = WIN_W'(1);
        end
        else if (32'(window_size_reg) > WINDOW_MAX)
        begin
            win_eff = WIN_W'(WINDOW_MAX);
        end
        else
        begin
            win_eff = WIN_W'(window_size_reg);
        end
    end

    assign cfg.ready     = 1'b1;
    assign samples.ready = !min_multi && !max_multi && (!out_valid_reg || results.ready);
    assign accept        = samples.valid && samples.ready;

    swmm_deque #(
        .IS_MIN       (1'b1),
        .WINDOW_MAX   (WINDOW_MAX),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .POS_W        (POS_W),
        .POS_MOD      (POS_MOD),
        .WIN_W        (WIN_W)
    ) u_min_deque (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .sample      (samples.sample),
        .pos_now     (pos_reg),
        .win_eff     (win_eff),
        .multi_stale (min_multi),
        .front_next  (min_front)
    );

    swmm_deque #(
        .IS_MIN       (1'b0),
        .WINDOW_MAX   (WINDOW_MAX),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .POS_W        (POS_W),
        .POS_MOD      (POS_MOD),
        .WIN_W        (WIN_W)
    ) u_max_deque (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .sample      (samples.sample),
        .pos_now     (pos_reg),
        .win_eff     (win_eff),
        .multi_stale (max_multi),
        .front_next  (max_front)
    );

    always_comb
    begin
        pos_next       = pos_reg;
        fill_next      = fill_reg;
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            pos_next  = (32'(pos_reg) == POS_MOD - 1) ? '0 : pos_reg + POS_W'(1);
            fill_next = (32'(fill_reg) < WINDOW_MAX) ? fill_reg + WIN_W'(1) : fill_reg;
        end
        if (accept)
        begin
            out_valid_next = (fill_next >= win_eff);
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= WINDOW_RESET;
            pos_reg         <= '0;
            fill_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                window_size_reg <= cfg.window_size;
            end
            pos_reg       <= pos_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            window_min_reg <= min_front;
            window_max_reg <= max_front;
        end
    end

    assign results.valid      = out_valid_reg;
    assign results.window_min = window_min_reg;
    assign results.window_max = window_max_reg;

    // a full window always yields a result beat
    a_emit: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (fill_next >= win_eff) |=> out_valid_reg)
        else $error("full window produced no result");

    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        32'(fill_reg) <= WINDOW_MAX)
        else $error("fill count past window limit");

    // both deques cover the same window
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (window_min_reg <= window_max_reg))
        else $error("window minimum above maximum");
endmodule

### tb/sv/tb_sliding_window_min_max.sv
// testbench for the sliding window min/max block: directed and random streams, self-checking
module tb_sliding_window_min_max;

    import swmm_pkg::*;

    localparam int WMAX         = WINDOW_MAX_DEF;
    localparam int SW           = SAMPLE_WIDTH_DEF;
    localparam int POS_SPAN     = 2 * WMAX;
    localparam int DRAIN_CYCLES = 8;
    localparam int LIMIT_CYCLES = 400000;
    localparam int PHASES       = 14;

    typedef logic signed [SW-1:0] sample_t;

    localparam sample_t S_MIN = {1'b1, {(SW-1){1'b0}}};
    localparam sample_t S_MAX = {1'b0, {(SW-1){1'b1}}};

    typedef struct packed {
        sample_t lo;
        sample_t hi;
    } extremes_t;

    typedef enum int {DQ_MIN = 0, DQ_MAX = 1} deque_kind_e;
    typedef enum int {MODE_WIDE, MODE_TIES, MODE_RISE, MODE_FALL, MODE_EDGE} sample_mode_e;
    typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC} stall_mode_e;

    logic clk;
    logic rst_n;

    swmm_cfg_if    cfg_ch ();
    swmm_sample_if sample_ch ();
    swmm_result_if result_ch ();

    sliding_window_min_max u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_ch),
        .samples (sample_ch),
        .results (result_ch)
    );

    // predictor state: two monotonic deques, front at index 0
    sample_t              dq_val [2][WMAX];
    int                   dq_pos [2][WMAX];
    int                   dq_len [2];
    int                   next_pos;
    int                   seen_count;
    logic [CFG_WIDTH-1:0] window_reg;
    extremes_t            pending_extremes[$];

    int          fail_count;
    int          cycle_count;
    int          burst_left;
    int          burst_max;
    int          gap_max;
    int          stall_tick;
    stall_mode_e stall_mode;
    sample_t     ramp_level;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void update_deque(deque_kind_e k, sample_t v, int win);
        int n;
        int drop;
        int age;
        int i;
        n = dq_len[k];
        drop = 0;
        while (drop < n)
        begin
            age = (next_pos + POS_SPAN - dq_pos[k][drop]) % POS_SPAN;
            if (age < win)
                break;
            drop++;
        end
        for (i = 0; i + drop < n; i++)
        begin
            dq_val[k][i] = dq_val[k][i + drop];
            dq_pos[k][i] = dq_pos[k][i + drop];
        end
        n -= drop;
        // strict domination only, so equal values stay queued
        while (n > 0 && ((k == DQ_MIN) ? (v < dq_val[k][n-1]) : (v > dq_val[k][n-1])))
            n--;
        if (n < WMAX)
        begin
            dq_val[k][n] = v;
            dq_pos[k][n] = next_pos;
            n++;
        end
        dq_len[k] = n;
    endfunction

    function automatic void predict_extremes(sample_t v);
        int win;
        if (window_reg == 0)
            win = 1;
        else if (window_reg > WMAX)
            win = WMAX;
        else
            win = window_reg;
        update_deque(DQ_MIN, v, win);
        update_deque(DQ_MAX, v, win);
        next_pos = (next_pos + 1) % POS_SPAN;
        if (seen_count < WMAX)
            seen_count++;
        if (seen_count >= win)
            pending_extremes.push_back('{lo: dq_val[DQ_MIN][0], hi: dq_val[DQ_MAX][0]});
    endfunction

    function automatic sample_t next_sample(sample_mode_e mode);
        case (mode)
            MODE_TIES:
                return sample_t'(int'($urandom_range(0, 4)) - 2);
            MODE_RISE:
            begin
                ramp_level = ramp_level + sample_t'($urandom_range(0, 3));
                return ramp_level;
            end
            MODE_FALL:
            begin
                ramp_level = ramp_level - sample_t'($urandom_range(0, 3));
                return ramp_level;
            end
            MODE_EDGE:
                case ($urandom_range(0, 3))
                    0: return S_MIN;
                    1: return S_MAX;
                    2: return '0;
                    default: return '1;
                endcase
            default:
                return sample_t'($urandom);
        endcase
    endfunction

    task automatic send_sample(input sample_t v);
        int gap;
        if (burst_left == 0)
        begin
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0)
            begin
                @(negedge clk);
                sample_ch.valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, burst_max);
        end
        @(negedge clk);
        sample_ch.valid  <= 1'b1;
        sample_ch.sample <= v;
        do @(posedge clk); while (!sample_ch.ready);
        predict_extremes(v);
        burst_left--;
    endtask

    task automatic wait_idle;
        @(negedge clk);
        sample_ch.valid <= 1'b0;
        burst_left = 0;
        while (pending_extremes.size() != 0)
            @(posedge clk);
        // a sample that yields no result may still be in flight
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_window(input logic [CFG_WIDTH-1:0] size);
        wait_idle();
        @(negedge clk);
        cfg_ch.valid       <= 1'b1;
        cfg_ch.window_size <= size;
        do @(posedge clk); while (!cfg_ch.ready);
        window_reg = size;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // reset window of one: every result is the sample itself
    task automatic test_reset_window;
        send_sample(S_MIN);
        send_sample(S_MAX);
        send_sample('0);
        send_sample('1);
        send_sample(sample_t'(1));
        send_sample(sample_t'(32'h5555_5555));
        send_sample(sample_t'(32'hAAAA_AAAA));
    endtask

    task automatic test_window_zero;
        write_window('0);
        send_sample(sample_t'(-7));
        send_sample(sample_t'(7));
    endtask

    task automatic test_equal_values;
        write_window(CFG_WIDTH'(3));
        send_sample(sample_t'(5));
        send_sample(sample_t'(5));
        send_sample(sample_t'(-2));
        send_sample(sample_t'(-2));
        send_sample(sample_t'(5));
        send_sample(sample_t'(5));
    endtask

    task automatic test_window_shrink;
        write_window(CFG_WIDTH'(2));
        send_sample(sample_t'(9));
        send_sample(sample_t'(-9));
        send_sample(sample_t'(9));
    endtask

    // growth keeps only what the smaller window held
    task automatic test_window_growth;
        write_window(CFG_WIDTH'(6));
        send_sample(sample_t'(1));
        send_sample(sample_t'(2));
    endtask

    function automatic logic [CFG_WIDTH-1:0] pick_window(int p);
        case (p)
            0:  return CFG_WIDTH'(WMAX);
            1:  return '1;
            2:  return CFG_WIDTH'(1);
            3:  return CFG_WIDTH'(WMAX + 1);
            4:  return '0;
            5:  return CFG_WIDTH'(2);
            6:  return CFG_WIDTH'(WMAX - 1);
            7:  return CFG_WIDTH'(WMAX / 2);
            13: return CFG_WIDTH'(WMAX);
            default: return CFG_WIDTH'($urandom_range(0, 127));
        endcase
    endfunction

    task automatic test_random_stream;
        int           p;
        int           k;
        int           items;
        int           run_left;
        sample_mode_e mode;
        mode = MODE_WIDE;
        for (p = 0; p < PHASES; p++)
        begin
            write_window(pick_window(p));
            case (p % 4)
                0:
                begin
                    gap_max = 0;
                    burst_max = 64;
                end
                1:
                begin
                    gap_max = 3;
                    burst_max = 4;
                end
                2:
                begin
                    gap_max = 8;
                    burst_max = 16;
                end
                default:
                begin
                    gap_max = 1;
                    burst_max = 1;
                end
            endcase
            stall_mode = stall_mode_e'(p % 3);
            items = $urandom_range(100, 150);
            run_left = 0;
            for (k = 0; k < items; k++)
            begin
                if (run_left == 0)
                begin
                    mode = sample_mode_e'($urandom_range(0, 4));
                    run_left = $urandom_range(8, 100);
                end
                send_sample(next_sample(mode));
                run_left--;
            end
        end
    endtask

    // receiver back-pressure
    always @(negedge clk)
    begin
        stall_tick <= (stall_tick + 1) % 13;
        case (stall_mode)
            STALL_NONE:     result_ch.ready <= 1'b1;
            STALL_RANDOM:   result_ch.ready <= ($urandom_range(0, 99) >= 35);
            default:        result_ch.ready <= (stall_tick >= 4);
        endcase
    end

    always @(posedge clk)
    begin : check_results
        extremes_t want;
        if (result_ch.valid && result_ch.ready)
        begin
            if (pending_extremes.size() == 0)
            begin
                $error("result beat with nothing pending: window_min %0d window_max %0d",
                       result_ch.window_min, result_ch.window_max);
                fail_count++;
            end
            else
            begin
                want = pending_extremes.pop_front();
                if (result_ch.window_min !== want.lo)
                begin
                    $error("window_min mismatch: expected %0d, got %0d",
                           want.lo, result_ch.window_min);
                    fail_count++;
                end
                if (result_ch.window_max !== want.hi)
                begin
                    $error("window_max mismatch: expected %0d, got %0d",
                           want.hi, result_ch.window_max);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("FAIL sliding_window_min_max");
            $finish;
        end
    end

    initial
    begin
        rst_n              = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.window_size = '0;
        sample_ch.valid    = 1'b0;
        sample_ch.sample   = '0;
        result_ch.ready    = 1'b0;
        fail_count  = 0;
        cycle_count = 0;
        stall_tick  = 0;
        stall_mode  = STALL_RANDOM;
        burst_left  = 0;
        burst_max   = 3;
        gap_max     = 2;
        ramp_level  = '0;
        next_pos    = 0;
        seen_count  = 0;
        dq_len[DQ_MIN] = 0;
        dq_len[DQ_MAX] = 0;
        window_reg  = WINDOW_RESET;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_window();
        test_window_zero();
        test_equal_values();
        test_window_shrink();
        test_window_growth();
        test_random_stream();
        wait_idle();

        if (fail_count == 0)
            $display("PASS sliding_window_min_max");
        else
            $display("FAIL sliding_window_min_max");
        $finish;
    end

endmodule

### sim.f
rtl/swmm_pkg.sv
rtl/swmm_sample_if.sv
rtl/swmm_result_if.sv
rtl/swmm_cfg_if.sv
rtl/swmm_cell.sv
rtl/swmm_deque.sv
rtl/sliding_window_min_max.sv
tb/sv/tb_sliding_window_min_max.sv
